// File: rtl/core/lcb_pkg.sv
package lcb_pkg;

  localparam int TB_W = 40;
  localparam int FW   = 32;

  typedef logic [2:0] status_t;
  typedef logic [1:0] action_t;

  localparam status_t ST_HIT      = 3'd0;
  localparam status_t ST_MISS     = 3'd1;
  localparam status_t ST_EVICTED  = 3'd2;
  localparam status_t ST_INSERTED = 3'd3;
  localparam status_t ST_PRESENT  = 3'd4;
  localparam status_t ST_REJECTED = 3'd5;
  localparam status_t ST_CLEARED  = 3'd6;

  localparam action_t ACT_GET   = 2'd0;
  localparam action_t ACT_PUT   = 2'd1;
  localparam action_t ACT_CLEAR = 2'd2;

  localparam logic CFG_LIMIT  = 1'b0;
  localparam logic CFG_BUDGET = 1'b1;

  typedef struct packed {
    logic          we;
    logic [FW-1:0] key;
    logic [FW-1:0] value;
  } ev_wr_t;

endpackage

// File: rtl/core/lcb_evict_fifo.sv
module lcb_evict_fifo #(
  parameter int N  = 17,
  parameter int AW = 5
) (
  input  logic                 clk,
  input  lcb_pkg::ev_wr_t      wr,
  input  logic [AW-1:0]        waddr,
  input  logic [AW-1:0]        raddr,
  output logic [lcb_pkg::FW-1:0] rkey,
  output logic [lcb_pkg::FW-1:0] rvalue
);
  import lcb_pkg::*;

  logic [FW-1:0] key_mem [N];
  logic [FW-1:0] val_mem [N];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      key_mem[waddr] <= wr.key;
      val_mem[waddr] <= wr.value;
    end
    rkey   <= key_mem[raddr];
    rvalue <= val_mem[raddr];
  end

endmodule

// File: rtl/core/lru_cache_with_byte_budget.sv
// lru cache with entry limit and byte budget
//
// input channel: an item (in_action, in_key, in_value, in_entry_size) is taken
// at a clock edge where start is high and busy is low. busy stays high while
// the item is worked on; no other item is taken meanwhile.
// result channel: each result is on the out_ ports for one cycle, marked by
// out_valid. evictions come first, oldest first, then one status result with
// out_last set. out_entries_held and out_bytes_held give the state after the
// whole item. the receiver cannot stall; results are never held back.
// a lookup reads (S_SRD) and compares (S_SCMP) slot by slot up to a hit or the
// last slot; after an insert each evicted entry, oldest first, goes to the fifo
// (S_EVCHK, S_EVRD), then eviction results (S_EMIT) and status (S_FIN) follow.
// a zero-value put, an unused action or a clear goes straight to S_FIN.
// configuration: cfg_we writes register cfg_index (0 entry limit, 1 byte budget)
// from cfg_data, not enforced: the user must write only while the block is idle.
// reset (synchronous, rst_n low) empties the store, sets limit 16, budget 0.
module lru_cache_with_byte_budget #(
  parameter int DEPTH      = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  parameter int SIZE_BITS  = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  lcb_pkg::action_t           in_action,
  input  logic [31:0]                in_key,
  input  logic [31:0]                in_value,
  input  logic [31:0]                in_entry_size,
  output logic                       out_valid,
  output lcb_pkg::status_t           out_status,
  output logic [31:0]                out_result_key,
  output logic [31:0]                out_result_value,
  output logic [4:0]                 out_entries_held,
  output logic [lcb_pkg::TB_W-1:0]   out_bytes_held,
  output logic                       out_last,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [31:0]                cfg_data
);
  import lcb_pkg::*;

  localparam int SLOTS = DEPTH + 1;
  localparam int IW    = $clog2(SLOTS);
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int LW    = (CW > 5) ? CW : 5;
  localparam int KS    = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int VS    = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int SS    = (SIZE_BITS < 32) ? SIZE_BITS : 32;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRD   = 3'd1;
  localparam logic [2:0] S_SCMP  = 3'd2;
  localparam logic [2:0] S_EVCHK = 3'd3;
  localparam logic [2:0] S_EVRD  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_r, state_nxt;

  logic [KS-1:0] key_mem  [SLOTS];
  logic [VS-1:0] val_mem  [SLOTS];
  logic [SS-1:0] size_mem [SLOTS];
  logic [KS-1:0] key_q;
  logic [VS-1:0] val_q;
  logic [SS-1:0] size_q;

  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [IW-1:0]    rank_r [SLOTS];
  logic [IW-1:0]    rank_nxt [SLOTS];
  logic [CW-1:0]    count_r, count_nxt;
  logic [TB_W-1:0]  total_r, total_nxt;
  logic [4:0]       limit_r;
  logic [31:0]      budget_r;

  action_t     act_r;
  logic [31:0] ikey_r, ival_r, isize_r;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] ev_slot_r, ev_slot_nxt;
  logic [CW-1:0] ev_cnt_r, ev_cnt_nxt;
  logic [IW-1:0] em_idx_r, em_idx_nxt;
  status_t     fin_st_r, fin_st_nxt;
  logic [31:0] fin_val_r, fin_val_nxt;

  logic        out_valid_r, out_last_r, src_fifo_r;
  status_t     out_st_r;
  logic [31:0] out_key_r, out_val_r;
  logic        emit_ev, emit_fin;

  logic [IW-1:0] rd_addr;
  logic          mem_we;
  logic [IW-1:0] free_slot, oldest;
  logic [LW-1:0] lim;
  logic          over;
  ev_wr_t        ev_wr;
  logic [31:0]   fifo_key, fifo_val;

  always_comb begin
    free_slot = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!valid_r[s]) free_slot = IW'(s);
    end
    oldest = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (valid_r[s] && (CW'(rank_r[s]) == count_r - CW'(1))) oldest = IW'(s);
    end
  end

  always_comb begin
    if (limit_r == 5'd0 || LW'(limit_r) > LW'(DEPTH)) lim = LW'(DEPTH);
    else lim = LW'(limit_r);
    over = (LW'(count_r) > lim) ||
           ((budget_r != 32'd0) && (total_r > TB_W'(budget_r)));
  end

  always_comb begin
    state_nxt   = state_r;
    valid_nxt   = valid_r;
    rank_nxt    = rank_r;
    count_nxt   = count_r;
    total_nxt   = total_r;
    idx_nxt     = idx_r;
    ev_slot_nxt = ev_slot_r;
    ev_cnt_nxt  = ev_cnt_r;
    em_idx_nxt  = em_idx_r;
    fin_st_nxt  = fin_st_r;
    fin_val_nxt = fin_val_r;
    rd_addr     = idx_r;
    mem_we      = 1'b0;
    emit_ev     = 1'b0;
    emit_fin    = 1'b0;
    ev_wr.we    = 1'b0;
    ev_wr.key   = 32'(key_q);
    ev_wr.value = 32'(val_q);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          idx_nxt     = '0;
          ev_cnt_nxt  = '0;
          em_idx_nxt  = '0;
          fin_val_nxt = '0;
          case (in_action)
            ACT_GET: state_nxt = S_SRD;
            ACT_PUT: begin
              if (in_value[VS-1:0] == '0) begin
                fin_st_nxt = ST_REJECTED;
                state_nxt  = S_FIN;
              end else begin
                state_nxt = S_SRD;
              end
            end
            ACT_CLEAR: begin
              valid_nxt = '0;
              for (int s = 0; s < SLOTS; s++) rank_nxt[s] = '0;
              count_nxt  = '0;
              total_nxt  = '0;
              fin_st_nxt = ST_CLEARED;
              state_nxt  = S_FIN;
            end
            default: begin
              fin_st_nxt = ST_MISS;
              state_nxt  = S_FIN;
            end
          endcase
        end
      end
      S_SRD: begin
        rd_addr   = idx_r;
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        if (valid_r[idx_r] && key_q == ikey_r[KS-1:0]) begin
          for (int t = 0; t < SLOTS; t++) begin
            if (valid_r[t] && rank_r[t] < rank_r[idx_r]) rank_nxt[t] = rank_r[t] + IW'(1);
          end
          rank_nxt[idx_r] = '0;
          if (act_r == ACT_GET) begin
            fin_st_nxt  = ST_HIT;
            fin_val_nxt = 32'(val_q);
          end else begin
            fin_st_nxt = ST_PRESENT;
          end
          state_nxt = S_FIN;
        end else if (idx_r != IW'(SLOTS - 1)) begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = S_SRD;
        end else if (act_r == ACT_GET) begin
          fin_st_nxt = ST_MISS;
          state_nxt  = S_FIN;
        end else begin
          mem_we = 1'b1;
          for (int t = 0; t < SLOTS; t++) begin
            if (valid_r[t]) rank_nxt[t] = rank_r[t] + IW'(1);
          end
          rank_nxt[free_slot]  = '0;
          valid_nxt[free_slot] = 1'b1;
          count_nxt  = count_r + CW'(1);
          total_nxt  = total_r + TB_W'(isize_r[SS-1:0]);
          fin_st_nxt = ST_INSERTED;
          state_nxt  = S_EVCHK;
        end
      end
      S_EVCHK: begin
        rd_addr = oldest;
        if (over && count_r != '0) begin
          ev_slot_nxt = oldest;
          state_nxt   = S_EVRD;
        end else if (ev_cnt_r != '0) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_EVRD: begin
        ev_wr.we  = 1'b1;
        valid_nxt[ev_slot_r] = 1'b0;
        rank_nxt[ev_slot_r]  = '0;
        count_nxt  = count_r - CW'(1);
        total_nxt  = total_r - TB_W'(size_q);
        ev_cnt_nxt = ev_cnt_r + CW'(1);
        state_nxt  = S_EVCHK;
      end
      S_EMIT: begin
        emit_ev    = 1'b1;
        em_idx_nxt = em_idx_r + IW'(1);
        if (CW'(em_idx_r) == ev_cnt_r - CW'(1)) state_nxt = S_FIN;
      end
      S_FIN: begin
        emit_fin  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      for (int s = 0; s < SLOTS; s++) rank_r[s] <= '0;
      count_r     <= '0;
      total_r     <= '0;
      limit_r     <= 5'd16;
      budget_r    <= '0;
      out_valid_r <= 1'b0;
      src_fifo_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      rank_r      <= rank_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= emit_ev | emit_fin;
      src_fifo_r  <= emit_ev;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LIMIT:  limit_r  <= cfg_data[4:0];
          CFG_BUDGET: budget_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    ev_slot_r <= ev_slot_nxt;
    ev_cnt_r  <= ev_cnt_nxt;
    em_idx_r  <= em_idx_nxt;
    fin_st_r  <= fin_st_nxt;
    fin_val_r <= fin_val_nxt;
    if (start && !busy) begin
      act_r   <= in_action;
      ikey_r  <= in_key;
      ival_r  <= in_value;
      isize_r <= in_entry_size;
    end
    if (emit_ev) begin
      out_st_r   <= ST_EVICTED;
      out_last_r <= 1'b0;
    end else if (emit_fin) begin
      out_st_r   <= fin_st_r;
      out_key_r  <= ikey_r;
      out_val_r  <= fin_val_r;
      out_last_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[free_slot]  <= ikey_r[KS-1:0];
      val_mem[free_slot]  <= ival_r[VS-1:0];
      size_mem[free_slot] <= isize_r[SS-1:0];
    end
    key_q  <= key_mem[rd_addr];
    val_q  <= val_mem[rd_addr];
    size_q <= size_mem[rd_addr];
  end

  lcb_evict_fifo #(
    .N  (SLOTS),
    .AW (IW)
  ) u_fifo (
    .clk    (clk),
    .wr     (ev_wr),
    .waddr  (ev_cnt_r[IW-1:0]),
    .raddr  (em_idx_r),
    .rkey   (fifo_key),
    .rvalue (fifo_val)
  );

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_st_r;
  assign out_result_key   = src_fifo_r ? fifo_key : out_key_r;
  assign out_result_value = src_fifo_r ? fifo_val : out_val_r;
  assign out_last         = out_last_r;
  assign out_entries_held = 5'(count_r);
  assign out_bytes_held   = total_r;

endmodule

// File: tb/tb_lru_cache_with_byte_budget.sv
module tb_lru_cache_with_byte_budget;
  import lcb_pkg::*;

  localparam int DEPTH = 16;
  localparam int SLOTS = DEPTH + 1;
  localparam logic [39:0] BYTES_SAT = 40'hFF_FFFF_FFFF;
  localparam logic [2:0] ST_NONE = 3'd7;

  typedef struct packed {
    status_t     status;
    logic [31:0] rkey;
    logic [31:0] rval;
    logic [4:0]  held;
    logic [39:0] bytes;
    logic        last;
  } res_t;

  typedef struct {
    action_t     act;
    logic [31:0] key;
    logic [31:0] val;
    logic [31:0] size;
    status_t     exp_status;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  action_t in_action = ACT_GET;
  logic [31:0] in_key = '0, in_value = '0, in_entry_size = '0;
  logic out_valid;
  status_t out_status;
  logic [31:0] out_result_key, out_result_value;
  logic [4:0] out_entries_held;
  logic [39:0] out_bytes_held;
  logic out_last;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  lru_cache_with_byte_budget i_dut (.*);

  always #1 clk = ~clk;

  logic [31:0] c_keys[SLOTS], c_vals[SLOTS], c_sizes[SLOTS];
  logic c_valid[SLOTS];
  int unsigned c_rank[SLOTS];
  int unsigned c_count;
  logic [63:0] c_bytes;
  logic [4:0] c_limit;
  logic [31:0] c_budget;

  res_t pending_results[$];
  status_t pending_status[$];
  int errors = 0;
  int sender_idle = 33;
  logic [31:0] hot_keys[8];

  function automatic int find_slot(logic [31:0] k);
    for (int s = 0; s < SLOTS; s++)
      if (c_valid[s] && c_keys[s] == k) return s;
    return -1;
  endfunction

  function automatic void touch(int s);
    for (int t = 0; t < SLOTS; t++)
      if (c_valid[t] && c_rank[t] < c_rank[s]) c_rank[t]++;
    c_rank[s] = 0;
  endfunction

  task automatic cache_clear();
    for (int s = 0; s < SLOTS; s++) begin
      c_valid[s] = 1'b0;
      c_rank[s] = 0;
    end
    c_count = 0;
    c_bytes = 0;
  endtask

  task automatic predict_access(action_t act, logic [31:0] k, logic [31:0] v,
                                logic [31:0] sz, status_t exp_st);
    res_t out_list[$];
    res_t r;
    int s, lim, best;
    r = '0;
    r.rkey = k;
    if (act == ACT_GET) begin
      s = find_slot(k);
      if (s >= 0) begin
        touch(s);
        r.status = ST_HIT;
        r.rval = c_vals[s];
      end else r.status = ST_MISS;
      out_list.push_back(r);
    end else if (act == ACT_PUT) begin
      s = find_slot(k);
      if (v == 0) begin
        r.status = ST_REJECTED;
        out_list.push_back(r);
      end else if (s >= 0) begin
        touch(s);
        r.status = ST_PRESENT;
        out_list.push_back(r);
      end else begin
        lim = (c_limit == 0 || c_limit > DEPTH) ? DEPTH : c_limit;
        for (s = 0; s < SLOTS && c_valid[s]; s++) ;
        if (s < SLOTS) begin
          for (int t = 0; t < SLOTS; t++) if (c_valid[t]) c_rank[t]++;
          c_keys[s] = k;
          c_vals[s] = v;
          c_sizes[s] = sz;
          c_valid[s] = 1'b1;
          c_rank[s] = 0;
          c_count++;
          c_bytes += sz;
        end
        while (c_count > lim || (c_budget != 0 && c_bytes > c_budget)) begin
          res_t e;
          best = -1;
          for (int t = 0; t < SLOTS; t++)
            if (c_valid[t] && (best < 0 || c_rank[t] > c_rank[best])) best = t;
          if (best < 0) break;
          c_valid[best] = 1'b0;
          c_rank[best] = 0;
          c_count--;
          c_bytes -= c_sizes[best];
          e = '0;
          e.status = ST_EVICTED;
          e.rkey = c_keys[best];
          e.rval = c_vals[best];
          out_list.push_back(e);
        end
        r.status = ST_INSERTED;
        out_list.push_back(r);
      end
    end else if (act == ACT_CLEAR) begin
      cache_clear();
      r.status = ST_CLEARED;
      out_list.push_back(r);
    end else begin
      r.status = ST_MISS;
      out_list.push_back(r);
    end
    foreach (out_list[i]) begin
      out_list[i].held = c_count[4:0];
      out_list[i].bytes = c_bytes > BYTES_SAT ? BYTES_SAT : c_bytes[39:0];
      out_list[i].last = (i == out_list.size() - 1);
      pending_results.push_back(out_list[i]);
      pending_status.push_back(i == out_list.size() - 1 ? exp_st : ST_NONE);
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    status_t typed;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result status %0d key %h", out_status, out_result_key);
        errors++;
      end else begin
        e = pending_results.pop_front();
        typed = pending_status.pop_front();
        if (typed != ST_NONE && out_status !== typed) begin
          $error("status (table): expected %0d actual %0d", typed, out_status);
          errors++;
        end
        if (out_status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, out_status);
          errors++;
        end
        if (out_result_key !== e.rkey) begin
          $error("result_key: expected %h actual %h", e.rkey, out_result_key);
          errors++;
        end
        if (out_result_value !== e.rval) begin
          $error("result_value: expected %h actual %h", e.rval, out_result_value);
          errors++;
        end
        if (out_entries_held !== e.held) begin
          $error("entries_held: expected %0d actual %0d", e.held, out_entries_held);
          errors++;
        end
        if (out_bytes_held !== e.bytes) begin
          $error("bytes_held: expected %h actual %h", e.bytes, out_bytes_held);
          errors++;
        end
        if (out_last !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, out_last);
          errors++;
        end
      end
    end
  end

  task automatic send_item(action_t act, logic [31:0] k, logic [31:0] v,
                           logic [31:0] sz, status_t exp_st);
    while ($urandom_range(99) < sender_idle) @(negedge clk);
    while (busy) @(negedge clk);
    in_action <= act;
    in_key <= k;
    in_value <= v;
    in_entry_size <= sz;
    start <= 1'b1;
    @(posedge clk);
    predict_access(act, k, v, sz, exp_st);
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [31:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LIMIT) c_limit = d[4:0];
    else c_budget = d;
  endtask

  task automatic random_phase(int n, logic [4:0] lim, logic [31:0] bud, int big_sizes);
    logic [31:0] k, sz;
    action_t act;
    int p;
    drain();
    write_cfg(CFG_LIMIT, {27'($urandom), lim});
    write_cfg(CFG_BUDGET, bud);
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      k = ($urandom_range(3) != 0) ? hot_keys[$urandom_range(7)] + $urandom_range(3)
                                   : $urandom;
      sz = big_sizes ? $urandom : $urandom_range(300);
      if (p < 35) act = ACT_GET;
      else if (p < 93) act = ACT_PUT;
      else if (p < 97) act = ACT_CLEAR;
      else act = action_t'(3);
      send_item(act, k, ($urandom_range(19) == 0) ? 32'd0 : $urandom, sz, ST_NONE);
    end
  endtask

  row_t dir_rows[$];

  initial begin
    cache_clear();
    c_limit = 5'd16;
    c_budget = '0;
    foreach (hot_keys[i]) hot_keys[i] = $urandom;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    dir_rows = '{
      '{ACT_GET,   32'h0,        32'h1,        32'h0,        ST_MISS},
      '{ACT_PUT,   32'h0,        32'h0,        32'h10,       ST_REJECTED},
      '{ACT_PUT,   32'h0,        32'hFFFF_FFFF, 32'hFFFF_FFFF, ST_INSERTED},
      '{ACT_PUT,   32'hFFFF_FFFF, 32'h1,        32'hFFFF_FFFF, ST_INSERTED},
      '{ACT_GET,   32'h0,        32'h0,        32'h0,        ST_HIT},
      '{ACT_PUT,   32'hFFFF_FFFF, 32'h5,        32'h1,        ST_PRESENT},
      '{action_t'(3), 32'hAAAA_5555, 32'h7,     32'h7,        ST_MISS},
      '{ACT_GET,   32'h5555_AAAA, 32'h0,       32'h0,        ST_MISS},
      '{ACT_CLEAR, 32'h1234_5678, 32'h0,       32'h0,        ST_CLEARED},
      '{ACT_GET,   32'h0,        32'h0,        32'h0,        ST_MISS}
    };
    foreach (dir_rows[i])
      send_item(dir_rows[i].act, dir_rows[i].key, dir_rows[i].val, dir_rows[i].size,
                dir_rows[i].exp_status);
    for (int i = 0; i < 18; i++)
      send_item(ACT_PUT, 32'h100 + i, 32'h200 + i, 32'h8000_0000, ST_INSERTED);
    send_item(ACT_GET, 32'h100, 32'h0, 32'h0, ST_MISS);

    // new entry larger than the budget evicts itself
    drain();
    write_cfg(CFG_BUDGET, 32'd100);
    send_item(ACT_PUT, 32'h900, 32'h1, 32'd101, ST_INSERTED);
    send_item(ACT_PUT, 32'h901, 32'h2, 32'd100, ST_INSERTED);
    drain();
    write_cfg(CFG_LIMIT, 32'd1);
    write_cfg(CFG_BUDGET, 32'd0);
    send_item(ACT_PUT, 32'h902, 32'h3, 32'd1, ST_INSERTED);
    send_item(ACT_PUT, 32'h903, 32'h4, 32'd1, ST_INSERTED);

    random_phase(170, 5'd3, 32'd600, 0);
    sender_idle = 53;
    random_phase(60, 5'd0, 32'd0, 1);
    random_phase(100, 5'd16, 32'hFFFF_FFFF, 0);
    random_phase(70, 5'd31, 32'd1000, 0);
    sender_idle = 0;
    random_phase(60, 5'd1, 32'd250, 0);
    random_phase(40, 5'd16, 32'd0, 1);

    drain();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: lru_cache_with_byte_budget.f
rtl/core/lcb_pkg.sv
rtl/core/lcb_evict_fifo.sv
rtl/core/lru_cache_with_byte_budget.sv
tb/tb_lru_cache_with_byte_budget.sv
